[src/assert_macros.svh]
// assertion macros shared by the checker files of the note parser
// needs no other file; take it in with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property, checked on the rising clock, off while reset is low
`define MNMP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// a signal holds while its channel is stalled
`define MNMP_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  `MNMP_ASSERT(lbl, clk, rstn, (vld) && !(rdy) |=> $stable(sig))

`endif

[src/mnmp_pkg.sv]
// types and constants of the midi note message parser
// used by every module of the block; depends on nothing
package mnmp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_PITCH  = 2'd1,
    PH_VEL    = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  // status byte command nibbles
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_PROGRAM  = 4'hC;
  localparam logic [3:0] CMD_PRESSURE = 4'hD;
  localparam logic [3:0] CMD_SYSTEM   = 4'hF;

  // skip counts
  localparam logic [1:0] SKIP_NONE   = 2'd0;
  localparam logic [1:0] SKIP_ONE    = 2'd1;
  localparam logic [1:0] SKIP_TWO    = 2'd2;
  localparam logic [1:0] SKIP_TO_END = 2'd3;

  localparam int unsigned OutDataW = 24;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_item_t;

  // one note event
  typedef struct packed {
    logic       note_on;
    logic [3:0] channel;
    logic [7:0] pitch;
    logic [7:0] velocity;
  } note_t;

endpackage

[src/midi_note_message_parser.sv]
// midi note message parser, top level
// depends on mnmp_pkg, mnmp_in_reg, mnmp_decode, mnmp_out_reg
//
// Input channel (s_axis): one MIDI byte per item in tdata, tlast marks the
// last byte of a packet. Output channel (m_axis): one note event per complete
// note-on or note-off message; tuser is 1 for note on, 0 for note off (a
// note-on with velocity zero comes out as note off, velocity zero).
// A byte is taken into the input register, decoded by the parser state and
// its event lands in the result register, which drives m_axis_tvalid_o.
// One byte per cycle is sustained while the receiver does not stall.
// Bytes that end no message update the parser state and give no item.
// When the receiver stalls, the result register holds its event and the
// input register can still take one more byte; s_axis_tready_o drops once
// both are full and follows m_axis_tready_i from then on.
// Reset clears both registers and returns the parser to waiting for a
// status byte with nothing held.
module midi_note_message_parser import mnmp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] data_byte
  input  logic                s_axis_tlast_i,  // packet_end
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // [3:0] channel, [11:4] pitch,
                                               // [19:12] velocity, [23:20] zero
  output logic                m_axis_tuser_o   // note_on
);

  in_item_t in_item, held_item;
  logic     held_valid, out_room, advance, note_valid;
  note_t    note, out_note;

  assign in_item.data_byte  = s_axis_tdata_i;
  assign in_item.packet_end = s_axis_tlast_i;

  // parser consumes the held byte when the result side has room
  assign advance = held_valid && out_room;

  mnmp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .valid_o   (held_valid),
    .advance_i (advance),
    .item_o    (held_item)
  );

  mnmp_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .item_i       (held_item),
    .note_valid_o (note_valid),
    .note_o       (note)
  );

  mnmp_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .note_valid_i (note_valid),
    .note_i       (note),
    .ready_o      (out_room),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .note_o       (out_note)
  );

  // pack the event
  assign m_axis_tdata_o = {4'd0, out_note.velocity, out_note.pitch, out_note.channel};
  assign m_axis_tuser_o = out_note.note_on;

endmodule

[src/mnmp_in_reg.sv]
// input register of the note parser: holds one byte until the parser takes it
// depends on mnmp_pkg
module mnmp_in_reg import mnmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     advance_i,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // free, or emptied in this cycle
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[src/mnmp_decode.sv]
// parser state machine: decodes one byte per advance and forms the note event
// depends on mnmp_pkg
module mnmp_decode import mnmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  in_item_t item_i,
  output logic     note_valid_o,
  output note_t    note_o
);

  phase_e     phase_q, phase_d;
  logic [1:0] left_q, left_d;
  logic [3:0] chan_q, chan_d;
  logic       is_on_q, is_on_d;
  logic [7:0] pitch_q, pitch_d;
  logic [3:0] cmd;
  logic       on;

  assign cmd = item_i.data_byte[7:4];
  assign on  = is_on_q && (item_i.data_byte != 8'd0);

  // next state and event
  always_comb begin
    phase_d      = phase_q;
    left_d       = left_q;
    chan_d       = chan_q;
    is_on_d      = is_on_q;
    pitch_d      = pitch_q;
    note_valid_o = 1'b0;
    note_o.note_on  = on;
    note_o.channel  = chan_q;
    note_o.pitch    = pitch_q;
    note_o.velocity = on ? item_i.data_byte : 8'd0;
    case (phase_q)
      PH_STATUS: begin
        if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
          chan_d  = item_i.data_byte[3:0];
          is_on_d = (cmd == CMD_NOTE_ON);
          phase_d = PH_PITCH;
        end else if (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE) begin
          phase_d = PH_SKIP;
          left_d  = SKIP_ONE;
        end else if (cmd == CMD_SYSTEM) begin
          phase_d = PH_SKIP;
          left_d  = SKIP_TO_END;
        end else if (item_i.data_byte[7]) begin
          phase_d = PH_SKIP;
          left_d  = SKIP_TWO;
        end
      end
      PH_PITCH: begin
        pitch_d = item_i.data_byte;
        phase_d = PH_VEL;
      end
      PH_VEL: begin
        note_valid_o = advance_i;
        phase_d      = PH_STATUS;
      end
      PH_SKIP: begin
        if (left_q != SKIP_TO_END) begin
          if (left_q == SKIP_TWO) begin
            left_d = SKIP_ONE;
          end else begin
            left_d  = SKIP_NONE;
            phase_d = PH_STATUS;
          end
        end
      end
      default: begin
        phase_d = PH_STATUS;
      end
    endcase
    // end of packet always restarts
    if (item_i.packet_end) begin
      phase_d = PH_STATUS;
      left_d  = SKIP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STATUS;
      left_q  <= SKIP_NONE;
      chan_q  <= 4'd0;
      is_on_q <= 1'b0;
      pitch_q <= 8'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      chan_q  <= chan_d;
      is_on_q <= is_on_d;
      pitch_q <= pitch_d;
    end
  end

endmodule

[src/mnmp_out_reg.sv]
// result register of the note parser: holds one note event for the receiver
// depends on mnmp_pkg
module mnmp_out_reg import mnmp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  logic  note_valid_i,
  input  note_t note_i,
  output logic  ready_o,
  output logic  valid_o,
  input  logic  ready_i,
  output note_t note_o
);

  logic  valid_q, valid_d;
  note_t note_q;

  // room when empty or being taken now
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q && !ready_i;
    if (advance_i) begin
      valid_d = note_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && note_valid_i) begin
      note_q <= note_i;
    end
  end

  assign valid_o = valid_q;
  assign note_o  = note_q;

endmodule

[src/mnmp_checker.sv]
// port-level checks for the midi note message parser, bound to the top level
// depends on mnmp_pkg and assert_macros.svh
`include "assert_macros.svh"

module mnmp_checker import mnmp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tuser_o
);

  // a waiting event keeps its payload
  `MNMP_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tready_i, m_axis_tdata_o)

  // note off always carries velocity zero
  `MNMP_ASSERT(a_off_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[19:12] == 8'd0)

  // note on never carries velocity zero
  `MNMP_ASSERT(a_on_nonzero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[19:12] != 8'd0)

  // padding bits stay zero
  `MNMP_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[23:20] == 4'd0)

  // an empty result register always frees the input side
  `MNMP_ASSERT(a_ready_free, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o)

endmodule

bind midi_note_message_parser mnmp_checker u_mnmp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

[tb/midi_note_message_parser_test.sv]
// self-checking testbench of the midi note message parser: streams MIDI packets and compares note items
// depends on mnmp_pkg and midi_note_message_parser; holds its own parser model in a scoreboard class
`timescale 1ns / 1ps

module midi_note_message_parser_test import mnmp_pkg::*;;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TargetItems   = 550;
  localparam int unsigned QuietFrom     = 480;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned MaxReports    = 10;

  // tracks the parser state and the note items still owed by the block
  class note_scoreboard;
    phase_e     phase;
    logic [1:0] skip_left;
    logic [3:0] held_channel;
    logic       held_on;
    logic [7:0] held_pitch;
    note_t      owed_notes[$];
    int unsigned errors;

    function new();
      phase        = PH_STATUS;
      skip_left    = SKIP_NONE;
      held_channel = '0;
      held_on      = 1'b0;
      held_pitch   = '0;
      errors       = 0;
    endfunction

    // advance the parser by one accepted byte
    function void take_byte(logic [7:0] b, logic last);
      note_t n;
      case (phase)
        PH_STATUS: begin
          case (b[7:4])
            CMD_NOTE_ON, CMD_NOTE_OFF: begin
              held_channel = b[3:0];
              held_on      = (b[7:4] == CMD_NOTE_ON);
              phase        = PH_PITCH;
            end
            CMD_PROGRAM, CMD_PRESSURE: begin
              phase     = PH_SKIP;
              skip_left = SKIP_ONE;
            end
            CMD_SYSTEM: begin
              phase     = PH_SKIP;
              skip_left = SKIP_TO_END;
            end
            default: begin
              // stray data bytes are dropped, other channel messages skip two
              if (b[7]) begin
                phase     = PH_SKIP;
                skip_left = SKIP_TWO;
              end
            end
          endcase
        end
        PH_PITCH: begin
          held_pitch = b;
          phase      = PH_VEL;
        end
        PH_VEL: begin
          // note on with zero velocity turns into note off
          n.note_on  = held_on && (b != 8'h00);
          n.channel  = held_channel;
          n.pitch    = held_pitch;
          n.velocity = n.note_on ? b : 8'h00;
          owed_notes = {owed_notes, n};
          phase = PH_STATUS;
        end
        default: begin
          if (skip_left != SKIP_TO_END) begin
            if (skip_left <= SKIP_ONE) begin
              skip_left = SKIP_NONE;
              phase     = PH_STATUS;
            end else begin
              skip_left = skip_left - 2'd1;
            end
          end
        end
      endcase
      // packet end always returns to waiting for a status byte
      if (last) begin
        phase     = PH_STATUS;
        skip_left = SKIP_NONE;
      end
    endfunction

    // compare one note item with the oldest owed one
    function void check_note(logic [OutDataW-1:0] data, logic on);
      note_t want;
      if (owed_notes.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected note item tuser=%b tdata=%h", $time, on, data);
        return;
      end
      want = owed_notes.pop_front();
      if (on !== want.note_on || data[3:0] !== want.channel || data[11:4] !== want.pitch ||
          data[19:12] !== want.velocity || data[OutDataW-1:20] !== '0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: note mismatch: expected on=%b ch=%h pitch=%h vel=%h, got on=%b tdata=%h",
                   $time, want.note_on, want.channel, want.pitch, want.velocity, on, data);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;
  logic                s_axis_tlast_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  note_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          quiet;
  bit          rx_hold_req;

  midi_note_message_parser u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // check every note item taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_note(m_axis_tdata_o, m_axis_tuser_o);
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("midi_note_message_parser_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        hold_left = LongHold;
      end else if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) m_axis_tready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left = $urandom_range(1, 7);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // offer one byte, with an occasional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_byte(b, last);
    items_sent++;
  endtask

  task automatic send_packet(input logic [7:0] pkt[$]);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  function automatic logic [7:0] data_value();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
  endfunction

  // add one byte at the tail of a packet
  function automatic void put_byte(ref logic [7:0] pkt[$], input logic [7:0] b);
    pkt = {pkt, b};
  endfunction

  // append one random message, mostly complete notes
  task automatic add_message(ref logic [7:0] pkt[$]);
    int unsigned kind;
    logic [7:0]  vel;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      put_byte(pkt, {($urandom_range(0, 1) ? CMD_NOTE_ON : CMD_NOTE_OFF),
                     4'($urandom_range(0, 15))});
      put_byte(pkt, data_value());
      vel = ($urandom_range(0, 9) == 0) ? 8'h00 : data_value();
      put_byte(pkt, vel);
    end else if (kind < 70) begin
      put_byte(pkt, {($urandom_range(0, 1) ? CMD_PROGRAM : CMD_PRESSURE),
                     4'($urandom_range(0, 15))});
      put_byte(pkt, data_value());
    end else if (kind < 80) begin
      case ($urandom_range(0, 2))
        0:       put_byte(pkt, {4'hA, 4'($urandom_range(0, 15))});
        1:       put_byte(pkt, {4'hB, 4'($urandom_range(0, 15))});
        default: put_byte(pkt, {4'hE, 4'($urandom_range(0, 15))});
      endcase
      put_byte(pkt, data_value());
      put_byte(pkt, data_value());
    end else if (kind < 86) begin
      put_byte(pkt, {CMD_SYSTEM, 4'($urandom_range(0, 15))});
      repeat ($urandom_range(0, 4)) put_byte(pkt, data_value());
    end else if (kind < 93) begin
      put_byte(pkt, 8'($urandom_range(0, 127)));
    end else begin
      // unfinished note, usually cut off by the packet end
      put_byte(pkt, {($urandom_range(0, 1) ? CMD_NOTE_ON : CMD_NOTE_OFF),
                     4'($urandom_range(0, 15))});
      if ($urandom_range(0, 1)) put_byte(pkt, data_value());
    end
  endtask

  // stimulus and end of run
  initial begin
    logic [7:0] pkt[$];
    bit         held_done;
    bit         pause_done;
    items_sent  = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    rx_hold_req = 1'b0;
    held_done   = 1'b0;
    pause_done  = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tlast_i  <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, zero velocity, velocity above 127, stray byte,
    // every skip length, system message to packet end, note cut by packet end
    send_packet('{8'h90, 8'h00, 8'h7F});
    send_packet('{8'h8F, 8'hFF, 8'hFF});
    send_packet('{8'h12, 8'h95, 8'h3C, 8'h00});
    send_packet('{8'hC3, 8'h85, 8'hD0, 8'h90, 8'hB1, 8'h01, 8'hF2, 8'h9A, 8'h40, 8'h80});
    send_packet('{8'hF0, 8'h93, 8'h11, 8'h22});
    send_packet('{8'h94, 8'h50});

    // random packets of one to three messages, sometimes cut short
    while (items_sent < TargetItems) begin
      pkt.delete();
      repeat ($urandom_range(1, 3)) add_message(pkt);
      if ($urandom_range(0, 9) == 0) pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
      send_packet(pkt);
      if (!held_done && items_sent >= 150) begin
        held_done   = 1'b1;
        rx_hold_req = 1'b1;
      end
      if (!pause_done && items_sent >= 300) begin
        pause_done = 1'b1;
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.owed_notes.size() != 0) @(posedge clk_i);
      end
      if (items_sent >= QuietFrom) quiet = 1'b1;
    end
    s_axis_tvalid_i <= 1'b0;

    // drain, then idle on to catch any stray item
    while (sb.owed_notes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_notes.size() == 0) begin
      $display("midi_note_message_parser_test: PASS");
    end else begin
      $display("midi_note_message_parser_test: FAIL");
    end
    $finish;
  end

endmodule

[midi_note_message_parser.f]
+incdir+src
src/mnmp_pkg.sv
src/mnmp_in_reg.sv
src/mnmp_decode.sv
src/mnmp_out_reg.sv
src/midi_note_message_parser.sv
src/mnmp_checker.sv
tb/midi_note_message_parser_test.sv
